FILE: rtl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg
// Shared types and constants of the latency bucket histogram.
// ----------------------------------------------------------------------------
package lbh_pkg;

   localparam int CNT_W      = 64;             // counter and latency width
   localparam int PCT_W      = 14;             // percentile register width
   localparam int PROD_W     = CNT_W + PCT_W;  // count * percentile
   localparam int REM_W      = 14;             // remainder of a divide by PCT_SCALE
   localparam int STEP_W     = 4;              // multiply and divide step counter
   localparam int IDX_OUT_W  = 5;              // reported bucket index width
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 392;            // 5 + 6 * 64 = 389, padded to bytes
   localparam int RSP_PAD_W  = RSP_DATA_W - (IDX_OUT_W + 6 * CNT_W);

   // divide by 10000 in 13-bit quotient digits
   localparam int DIG_W      = 13;
   localparam int DIV_DIGITS = PROD_W / DIG_W;             // 6 digits cover the product
   localparam int NUM_W      = REM_W + DIG_W;              // partial dividend
   localparam int PRE_SHIFT  = 4;                          // 10000 = 16 * 625
   localparam int MAG_W      = 24;
   localparam int MAG_SHIFT  = 33;
   localparam int MPROD_W    = NUM_W - PRE_SHIFT + MAG_W;
   localparam logic [MAG_W-1:0] DIV_MAGIC = 24'd13743896;  // ceil(2^33 / 625)

   localparam logic [PCT_W-1:0] PCT_RESET = 14'd9900;
   localparam logic [REM_W:0]   PCT_SCALE = 15'd10000;

   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_FLUSH   = 1'b1;

   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [PROD_W-1:0] prod_type;

   localparam int BOUND_LEN = 21;
   localparam cnt_type BOUND_TABLE [0:BOUND_LEN-1] = '{
      64'd1000,       64'd2000,       64'd5000,       64'd10000,
      64'd20000,      64'd50000,      64'd100000,     64'd200000,
      64'd500000,     64'd1000000,    64'd2000000,    64'd5000000,
      64'd10000000,   64'd20000000,   64'd50000000,   64'd100000000,
      64'd200000000,  64'd500000000,  64'd1000000000, 64'd2000000000,
      64'd5000000000
   };

endpackage

FILE: rtl/latency_bucket_histogram.sv
// ----------------------------------------------------------------------------
// latency_bucket_histogram
// Fixed-bound latency histogram with interval counters and a percentile
// report on flush.
// ----------------------------------------------------------------------------
// Observe beats (tuser = 0) are taken one per cycle while no flush is in
// progress; the bucket counters live in a RAM updated by a two-stage
// read-modify-write with forwarding, so back-to-back hits on one bucket are
// counted correctly. A flush beat (tuser = 1) holds off the request side
// until the last bucket is emitted, response stalls included: a shift-add
// multiply of the interval count by the percentile, a divide by 10000 for
// the target (six 13-bit quotient digits, each a reciprocal-multiply step
// and then a remainder step), then per bucket a RAM read and an emit,
// where the bucket is cleared and the running sum checked against the
// target. The response register lets the block keep working while a beat
// waits. Unwritten RAM entries read as zero through per-entry valid bits, so
// no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module latency_bucket_histogram #(
   parameter int NUM_BUCKETS = 22
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = latency_ns[63:0]; tuser = func[0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lbh_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [0:0]                      req_tuser,
   // response: tdata = bucket_index[4:0], bucket_count[68:5],
   // bucket_bound[132:69], interval_count[196:133], interval_sum[260:197],
   // lifetime_count[324:261], percentile_bound[388:325], zero pad[391:389]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lbh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // percentile register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbh_pkg::PCT_W-1:0]       csr_data
);

   import lbh_pkg::*;

   localparam int IDX_W = $clog2(NUM_BUCKETS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   function automatic cnt_type bound_of(input logic [IDX_W-1:0] i);
      int unsigned iu;
      iu = 32'(i);
      if (iu + 1 >= NUM_BUCKETS || iu >= BOUND_LEN) begin
         return '1;
      end
      return BOUND_TABLE[iu];
   endfunction

   function automatic logic [IDX_W-1:0] bucket_of(input cnt_type ns);
      logic [IDX_W-1:0] b;
      b = IDX_W'(NUM_BUCKETS - 1);
      for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
         if (bound_of(IDX_W'(i)) >= ns) begin
            b = IDX_W'(i);
         end
      end
      return b;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [PCT_W-1:0]        pct_ff, pct_in;
   logic [2:0]              st_ff, st_in;
   logic                    v1_ff, v1_in;
   cnt_type                 ns1_ff, ns1_in;
   logic                    v2_ff, v2_in;
   logic [IDX_W-1:0]        idx2_ff, idx2_in;
   logic                    wv_ff, wv_in;
   logic [IDX_W-1:0]        widx_ff, widx_in;
   cnt_type                 wdata_ff, wdata_in;
   cnt_type                 icnt_ff, icnt_in;
   cnt_type                 isum_ff, isum_in;
   cnt_type                 life_ff, life_in;
   logic [NUM_BUCKETS-1:0]  valid_ff, valid_in;
   logic                    rdv_ff, rdv_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   prod_type                mcand_ff, mcand_in;
   logic [PCT_W-1:0]        mult_ff, mult_in;
   prod_type                acc_ff, acc_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [DIG_W-1:0]        qdig_ff, qdig_in;
   cnt_type                 target_ff, target_in;
   cnt_type                 cum_ff, cum_in;
   logic                    found_ff, found_in;
   cnt_type                 pb_ff, pb_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- RAM port
   logic                    ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]        ram_wr_addr, ram_rd_addr;
   cnt_type                 ram_wr_data, ram_rd_data;

   lbh_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BUCKETS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- datapath
   logic                    req_acc, obs_acc, flush_acc;
   logic                    rsp_free, emit_go, last_k;
   logic [IDX_W-1:0]        idx1;
   cnt_type                 ram_word, cur2, new2;
   cnt_type                 cum_sum, pb_out;
   logic                    hit;
   logic [NUM_W-1:0]        div_num, div_qd, div_rem;
   logic [MPROD_W-1:0]      div_prod;
   logic [DIG_W-1:0]        div_q;
   cnt_type                 quot_sat;
   logic [IDX_W+4:0]        k_ext;

   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign obs_acc    = req_acc && (req_tuser[0] == FUNC_OBSERVE);
   assign flush_acc  = req_acc && (req_tuser[0] == FUNC_FLUSH);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign emit_go    = (st_ff == ST_EMIT) && rsp_free;
   assign last_k     = (k_ff == IDX_W'(NUM_BUCKETS - 1));

   assign idx1       = bucket_of(ns1_ff);
   assign ram_word   = rdv_ff ? ram_rd_data : '0;
   // the previous write lands on the same edge as this read, so take it here
   assign cur2       = (wv_ff && (widx_ff == idx2_ff)) ? wdata_ff : ram_word;
   assign new2       = cur2 + 64'd1;

   assign cum_sum    = cum_ff + ram_word;
   assign hit        = (cum_sum >= target_ff);
   assign pb_out     = (icnt_ff == '0) ? '0 :
                       (found_ff ? pb_ff : bound_of(IDX_W'(NUM_BUCKETS - 1)));
   assign k_ext      = {5'd0, k_ff};

   // partial dividend = remainder : next digit; floor(n / 10000) is
   // floor((n >> 4) / 625), done as a reciprocal multiply
   assign div_num    = {rem_ff, acc_ff[PROD_W-1 -: DIG_W]};
   assign div_prod   = MPROD_W'(div_num[NUM_W-1:PRE_SHIFT]) * MPROD_W'(DIV_MAGIC);
   assign div_q      = div_prod[MAG_SHIFT+DIG_W-1:MAG_SHIFT];
   assign div_qd     = NUM_W'(qdig_ff) * NUM_W'(PCT_SCALE);
   assign div_rem    = div_num - div_qd;
   assign quot_sat   = (|acc_ff[PROD_W-1:CNT_W]) ? '1 : acc_ff[CNT_W-1:0];

   assign ram_rd_en   = (st_ff == ST_RD) || v1_ff;
   assign ram_rd_addr = (st_ff == ST_RD) ? k_ff : idx1;
   assign ram_wr_en   = emit_go || v2_ff;
   assign ram_wr_addr = emit_go ? k_ff : idx2_ff;
   assign ram_wr_data = emit_go ? '0 : new2;

   always_comb begin
      pct_in       = pct_ff;
      st_in        = st_ff;
      v1_in        = obs_acc;
      ns1_in       = obs_acc ? req_tdata : ns1_ff;
      v2_in        = v1_ff;
      idx2_in      = idx1;
      wv_in        = v2_ff;
      widx_in      = idx2_ff;
      wdata_in     = new2;
      icnt_in      = icnt_ff;
      isum_in      = isum_ff;
      life_in      = life_ff;
      valid_in     = valid_ff;
      rdv_in       = ram_rd_en ? valid_ff[ram_rd_addr] : rdv_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      mcand_in     = mcand_ff;
      mult_in      = mult_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      qdig_in      = qdig_ff;
      target_in    = target_ff;
      cum_in       = cum_ff;
      found_in     = found_ff;
      pb_in        = pb_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid) begin
         pct_in = csr_data;
      end

      if (obs_acc) begin
         icnt_in = icnt_ff + 64'd1;
         isum_in = isum_ff + req_tdata;
         life_in = life_ff + 64'd1;
      end

      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end

      case (st_ff)
         ST_IDLE: begin
            if (flush_acc) begin
               st_in    = ST_MUL;
               step_in  = '0;
               acc_in   = '0;
               mcand_in = PROD_W'(icnt_ff);
               mult_in  = pct_ff;
               rem_in   = '0;
               k_in     = '0;
               cum_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_MUL: begin
            if (mult_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[PROD_W-2:0], 1'b0};
            mult_in  = {1'b0, mult_ff[PCT_W-1:1]};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(PCT_W - 1)) begin
               st_in   = ST_DIV;
               step_in = '0;
            end
         end
         ST_DIV: begin
            // even step: quotient digit; odd step: remainder, digit shifts in
            if (!step_ff[0]) begin
               qdig_in = div_q;
            end else begin
               rem_in = div_rem[REM_W-1:0];
               acc_in = {acc_ff[PROD_W-DIG_W-1:0], qdig_ff};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(2 * DIV_DIGITS - 1)) begin
               st_in = ST_RD;
            end
         end
         ST_RD: begin
            if (step_ff == STEP_W'(2 * DIV_DIGITS)) begin
               // first pass through: acc holds the quotient
               target_in = (quot_sat == '0) ? 64'd1 : quot_sat;
               step_in   = '0;
            end
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_k;
               rsp_data_in  = {{RSP_PAD_W{1'b0}},
                               (last_k ? pb_out : 64'd0),
                               life_ff, isum_ff, icnt_ff,
                               bound_of(k_ff), ram_word,
                               k_ext[IDX_OUT_W-1:0]};
               cum_in = cum_sum;
               if (!found_ff && hit) begin
                  found_in = 1'b1;
                  pb_in    = bound_of(k_ff);
               end
               if (last_k) begin
                  st_in   = ST_IDLE;
                  icnt_in = '0;
                  isum_in = '0;
               end else begin
                  st_in = ST_RD;
                  k_in  = k_ff + 1'b1;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff       <= PCT_RESET;
         st_ff        <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         wv_ff        <= 1'b0;
         icnt_ff      <= '0;
         isum_ff      <= '0;
         life_ff      <= '0;
         valid_ff     <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pct_ff       <= pct_in;
         st_ff        <= st_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         wv_ff        <= wv_in;
         icnt_ff      <= icnt_in;
         isum_ff      <= isum_in;
         life_ff      <= life_in;
         valid_ff     <= valid_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ns1_ff      <= ns1_in;
      idx2_ff     <= idx2_in;
      widx_ff     <= widx_in;
      wdata_ff    <= wdata_in;
      k_ff        <= k_in;
      step_ff     <= step_in;
      mcand_ff    <= mcand_in;
      mult_ff     <= mult_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      qdig_ff     <= qdig_in;
      target_ff   <= target_in;
      cum_ff      <= cum_in;
      pb_ff       <= pb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   // observe pipeline must be empty before flush starts clearing buckets
   a_no_wr_clash: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EMIT) |-> !v2_ff)
      else $error("observe write overlaps flush clear");

   a_life_bump: assert property (@(posedge clock) disable iff (reset)
      obs_acc |=> (life_ff == $past(life_ff) + 64'd1))
      else $error("lifetime count missed an observe");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (rem_ff < PCT_SCALE[REM_W-1:0]))
      else $error("divider remainder out of range");

   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      (emit_go && last_k) |=> (icnt_ff == '0 && isum_ff == '0 && rsp_tlast))
      else $error("interval not cleared at end of flush");

endmodule

FILE: rtl/lbh_ram.sv
// ----------------------------------------------------------------------------
// lbh_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// Read during a write to the same address returns the old word.
// ----------------------------------------------------------------------------
module lbh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
